[src/mpsr_pkg.sv]
package mpsr_pkg;

  // request codes
  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_STOP  = 3'd1;
  localparam logic [2:0] REQ_TICK  = 3'd2;
  localparam logic [2:0] REQ_ESTOP = 3'd3;
  localparam logic [2:0] REQ_OFF   = 3'd4;

  // direction codes
  localparam logic [1:0] DIR_NONE     = 2'd0;
  localparam logic [1:0] DIR_CONTRACT = 2'd1;
  localparam logic [1:0] DIR_EXTEND   = 2'd2;
  localparam logic [1:0] DIR_INVALID  = 2'd3;

  // reported motor state codes
  localparam logic [1:0] MS_INACTIVE = 2'd0;
  localparam logic [1:0] MS_STARTING = 2'd1;
  localparam logic [1:0] MS_ACTIVE   = 2'd2;
  localparam logic [1:0] MS_STOPPING = 2'd3;

  localparam int unsigned DUTY_FULL     = 100;
  localparam int unsigned W_DEN_SCALE   = 1600;  // 16 * 100
  localparam int unsigned T_DEN_SCALE   = 64;
  localparam int unsigned FREQ_MAX      = 255;
  localparam logic [7:0]  FREQ_RST      = 8'd20;
  localparam int unsigned DEN_W         = $clog2(FREQ_MAX * W_DEN_SCALE + 1);

  typedef enum logic [3:0] {
    MODE_INACTIVE = 4'b0001,
    MODE_STARTING = 4'b0010,
    MODE_ACTIVE   = 4'b0100,
    MODE_STOPPING = 4'b1000
  } mode_e;

  typedef enum logic [2:0] {
    UOP_IDLE,
    UOP_DECODE,
    UOP_DIV,
    UOP_WIDTH,
    UOP_TLOAD,
    UOP_TPER,
    UOP_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_NO_ACCEPT,
    C_NO_WIDTH,
    C_DIV_MORE,
    C_OUT_BLOCKED
  } cond_e;

  typedef logic [2:0] step_t;

  localparam step_t ST_WAIT   = 3'd0;
  localparam step_t ST_DECODE = 3'd1;
  localparam step_t ST_WDIV   = 3'd2;
  localparam step_t ST_WIDTH  = 3'd3;
  localparam step_t ST_TLOAD  = 3'd4;
  localparam step_t ST_TDIV   = 3'd5;
  localparam step_t ST_TPER   = 3'd6;
  localparam step_t ST_EMIT   = 3'd7;

  // taken cond jumps to target, otherwise step + 1 (wraps after ST_EMIT)
  typedef struct packed {
    logic  in_rdy;
    uop_e  op;
    cond_e cond;
    step_t target;
  } uc_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  function automatic uc_t ucode(input step_t s);
    uc_t u;
    u = '{in_rdy: 1'b0, op: UOP_IDLE, cond: C_NONE, target: ST_WAIT};
    case (s)
      ST_WAIT:   u = '{in_rdy: 1'b1, op: UOP_IDLE,   cond: C_NO_ACCEPT,   target: ST_WAIT};
      ST_DECODE: u = '{in_rdy: 1'b0, op: UOP_DECODE, cond: C_NO_WIDTH,    target: ST_TLOAD};
      ST_WDIV:   u = '{in_rdy: 1'b0, op: UOP_DIV,    cond: C_DIV_MORE,    target: ST_WDIV};
      ST_WIDTH:  u = '{in_rdy: 1'b0, op: UOP_WIDTH,  cond: C_NONE,        target: ST_WAIT};
      ST_TLOAD:  u = '{in_rdy: 1'b0, op: UOP_TLOAD,  cond: C_NONE,        target: ST_WAIT};
      ST_TDIV:   u = '{in_rdy: 1'b0, op: UOP_DIV,    cond: C_DIV_MORE,    target: ST_TDIV};
      ST_TPER:   u = '{in_rdy: 1'b0, op: UOP_TPER,   cond: C_NONE,        target: ST_WAIT};
      ST_EMIT:   u = '{in_rdy: 1'b0, op: UOP_EMIT,   cond: C_OUT_BLOCKED, target: ST_EMIT};
      default:   u = '{in_rdy: 1'b0, op: UOP_IDLE,   cond: C_NONE,        target: ST_WAIT};
    endcase
    return u;
  endfunction

  function automatic logic [1:0] mode_code(input mode_e m);
    logic [1:0] c;
    case (m)
      MODE_INACTIVE: c = MS_INACTIVE;
      MODE_STARTING: c = MS_STARTING;
      MODE_ACTIVE:   c = MS_ACTIVE;
      MODE_STOPPING: c = MS_STOPPING;
      default:       c = MS_INACTIVE;
    endcase
    return c;
  endfunction

endpackage

[src/mpsr_div.sv]
module mpsr_div #(
  parameter int unsigned NUM_W = 23,
  parameter int unsigned DW    = 19
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mpsr_pkg::div_ctl_t         ctl_i,
  input  logic [NUM_W-1:0]           num_i,
  input  logic [DW-1:0]              den_i,
  output logic [NUM_W-1:0]           quo_o,
  output logic                       last_o
);
  import mpsr_pkg::*;

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    den_q;
  logic [NUM_W-1:0] num_q, num_d;
  logic [CW-1:0]    cnt_q;
  logic [DW+1:0]    diff;
  logic             ge;

  // restoring division, one quotient bit per step, quotient shifts into num_q
  always_comb begin
    diff  = {1'b0, rem_q, num_q[NUM_W-1]} - {2'b00, den_q};
    ge    = ~diff[DW+1];
    rem_d = ge ? diff[DW-1:0] : {rem_q[DW-2:0], num_q[NUM_W-1]};
    num_d = {num_q[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.load) begin
      cnt_q <= CW'(NUM_W);
    end else if (ctl_i.step) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      rem_q <= '0;
      num_q <= num_i;
      den_q <= den_i;
    end else if (ctl_i.step) begin
      rem_q <= rem_d;
      num_q <= num_d;
    end
  end

  assign quo_o  = num_q;
  assign last_o = (cnt_q == CW'(1));

endmodule

[src/motor_pwm_soft_ramp_top.sv]
// Channel | Dir | Handshake                  | Beat
// --------+-----+----------------------------+-----------------------------------------
// in      | in  | in_valid_i / in_ready_o    | req_type, direction, target_duty
// out     | out | out_valid_o / out_ready_i  | pulse_width .. timer_period
// cfg     | in  | cfg_valid_i / cfg_ready_o  | cfg_pwm_freq_khz_i (always ready)
//
// Each item runs the bit-serial divider, one quotient bit per cycle over NW bits, NW
// being the numerator width (23 at the default clock): once for the duty width when
// it is recomputed, and once for the timer period.
// The next request is taken while a result still sits in the output register.
// A stalled output holds the sequencer in its emit step only.
// Reset is asynchronous, active low; the frequency register resets to 20.
module motor_pwm_soft_ramp_top #(
  parameter int unsigned CLOCK_KHZ    = 64000,
  parameter int unsigned MIN_FREQ_KHZ = 4,
  parameter int unsigned REST_DUTY    = 50
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_pwm_freq_khz_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] req_type_i,
  input  logic [1:0] direction_i,
  input  logic [6:0] target_duty_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [9:0] pulse_width_o,
  output logic       bridge_enable_o,
  output logic       outputs_shutdown_o,
  output logic       ramp_timer_run_o,
  output logic [1:0] motor_state_o,
  output logic       ramp_done_o,
  output logic [7:0] timer_period_o
);
  import mpsr_pkg::*;

  localparam int unsigned NUM_W = $clog2(DUTY_FULL * CLOCK_KHZ + 1);
  localparam logic [6:0]  REST7 = 7'(REST_DUTY);

  // sequencer
  step_t step_q, step_d;
  uc_t   uc;
  logic  take;

  // request and config
  logic [2:0] req_q;
  logic [1:0] dir_q;
  logic [6:0] tgt_q;
  logic [7:0] freq_q;
  logic [7:0] f_eff;

  // controller state
  mode_e      mode_q, mode_c;
  logic [1:0] adir_q, adir_c;
  logic [6:0] start_step_q, start_step_c;
  logic [6:0] stop_step_q, stop_step_c;
  logic [6:0] ramp_tgt_q, ramp_tgt_c;
  logic [9:0] cur_width_q;
  logic       shut_q, shut_c;
  logic       emerg_q, done_q;
  logic [7:0] tper_q;

  // decode results
  logic       upd_c, emerg_c, done_c;
  logic [6:0] duty_c, dval_c, ss_dec, sp_inc, tgt_clamp;
  logic [1:0] sdir_c;

  // divider
  div_ctl_t         dctl;
  logic [NUM_W-1:0] num_c, quo;
  logic [DEN_W-1:0] den_c;
  logic             div_last;
  logic [9:0]       estop_w;

  // output register
  logic       out_valid_q;
  logic [9:0] o_width_q;
  logic       o_bridge_q, o_shut_q, o_run_q, o_done_q;
  logic [1:0] o_state_q;
  logic [7:0] o_tper_q;

  assign uc          = ucode(step_q);
  assign in_ready_o  = uc.in_rdy;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    case (uc.cond)
      C_NONE:        take = 1'b0;
      C_NO_ACCEPT:   take = ~in_valid_i;
      C_NO_WIDTH:    take = ~upd_c;
      C_DIV_MORE:    take = ~div_last;
      C_OUT_BLOCKED: take = out_valid_q & ~out_ready_i;
      default:       take = 1'b0;
    endcase
    step_d = take ? uc.target : step_q + 3'd1;
  end

  assign f_eff = (freq_q < 8'(MIN_FREQ_KHZ)) ? 8'(MIN_FREQ_KHZ) : freq_q;

  // state update for one request
  always_comb begin
    mode_c       = mode_q;
    adir_c       = adir_q;
    start_step_c = start_step_q;
    stop_step_c  = stop_step_q;
    ramp_tgt_c   = ramp_tgt_q;
    shut_c       = shut_q;
    upd_c        = 1'b0;
    emerg_c      = 1'b0;
    done_c       = 1'b0;
    duty_c       = REST7;
    sdir_c       = adir_q;
    ss_dec       = start_step_q - 7'd1;
    sp_inc       = stop_step_q + 7'd1;
    if (tgt_q < 7'd1) begin
      tgt_clamp = 7'd1;
    end else if (tgt_q > REST7) begin
      tgt_clamp = REST7;
    end else begin
      tgt_clamp = tgt_q;
    end
    case (req_q)
      REQ_START: begin
        if (mode_q == MODE_INACTIVE) begin
          ramp_tgt_c   = tgt_clamp;
          adir_c       = dir_q;
          mode_c       = MODE_STARTING;
          start_step_c = REST7;
          duty_c       = REST7;
          sdir_c       = dir_q;
          upd_c        = 1'b1;
          shut_c       = 1'b0;
        end
      end
      REQ_STOP: begin
        if (mode_q == MODE_ACTIVE) begin
          mode_c = MODE_STOPPING;
        end
      end
      REQ_TICK: begin
        if (mode_q == MODE_STARTING) begin
          start_step_c = ss_dec;
          duty_c       = ss_dec;
          upd_c        = 1'b1;
          if (ss_dec < ramp_tgt_q) begin
            stop_step_c = ramp_tgt_q;
            mode_c      = MODE_ACTIVE;
            done_c      = 1'b1;
          end
        end else if (mode_q == MODE_STOPPING) begin
          duty_c      = stop_step_q;
          upd_c       = 1'b1;
          stop_step_c = sp_inc;
          if (sp_inc > REST7) begin
            shut_c = 1'b1;
            mode_c = MODE_INACTIVE;
            adir_c = DIR_NONE;
            done_c = 1'b1;
          end
        end
      end
      REQ_ESTOP: begin
        emerg_c = 1'b1;
        upd_c   = 1'b1;
        shut_c  = 1'b1;
        mode_c  = MODE_INACTIVE;
        adir_c  = DIR_NONE;
      end
      REQ_OFF: begin
        if (mode_q != MODE_INACTIVE) begin
          shut_c = 1'b1;
          mode_c = MODE_INACTIVE;
          adir_c = DIR_NONE;
        end
      end
      default: ;
    endcase
    // an invalid direction leaves the width alone, except on an emergency stop
    if (!emerg_c && sdir_c == DIR_INVALID) begin
      upd_c = 1'b0;
    end
    if (sdir_c == DIR_EXTEND) begin
      dval_c = (duty_c <= 7'(DUTY_FULL)) ? 7'(DUTY_FULL) - duty_c : 7'd0;
    end else begin
      dval_c = duty_c;
    end
  end

  always_comb begin
    dctl.load = (uc.op == UOP_DECODE) || (uc.op == UOP_TLOAD);
    dctl.step = (uc.op == UOP_DIV);
    if (uc.op == UOP_TLOAD) begin
      num_c = NUM_W'(CLOCK_KHZ);
      den_c = DEN_W'(f_eff) * DEN_W'(T_DEN_SCALE);
    end else begin
      num_c = emerg_c ? NUM_W'(CLOCK_KHZ) : NUM_W'(dval_c) * NUM_W'(CLOCK_KHZ);
      den_c = DEN_W'(f_eff) * DEN_W'(W_DEN_SCALE);
    end
  end

  mpsr_div #(
    .NUM_W (NUM_W),
    .DW    (DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dctl),
    .num_i  (num_c),
    .den_i  (den_c),
    .quo_o  (quo),
    .last_o (div_last)
  );

  // only the low bits of the product are kept
  assign estop_w = quo[9:0] * 10'(REST_DUTY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= ST_WAIT;
      freq_q       <= FREQ_RST;
      mode_q       <= MODE_INACTIVE;
      adir_q       <= DIR_NONE;
      start_step_q <= '0;
      stop_step_q  <= '0;
      ramp_tgt_q   <= '0;
      cur_width_q  <= '0;
      shut_q       <= 1'b1;
      emerg_q      <= 1'b0;
      done_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      if (cfg_valid_i) begin
        freq_q <= cfg_pwm_freq_khz_i;
      end
      if (uc.op == UOP_DECODE) begin
        mode_q       <= mode_c;
        adir_q       <= adir_c;
        start_step_q <= start_step_c;
        stop_step_q  <= stop_step_c;
        ramp_tgt_q   <= ramp_tgt_c;
        shut_q       <= shut_c;
        emerg_q      <= emerg_c;
        done_q       <= done_c;
      end
      if (uc.op == UOP_WIDTH) begin
        cur_width_q <= emerg_q ? estop_w : quo[9:0];
      end
      if (uc.op == UOP_EMIT && !take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && uc.in_rdy) begin
      req_q <= req_type_i;
      dir_q <= direction_i;
      tgt_q <= target_duty_i;
    end
    if (uc.op == UOP_TPER) begin
      tper_q <= quo[7:0] - 8'd1;
    end
    if (uc.op == UOP_EMIT && !take) begin
      o_width_q  <= cur_width_q;
      o_bridge_q <= (mode_q != MODE_INACTIVE);
      o_shut_q   <= shut_q;
      o_run_q    <= (mode_q == MODE_STARTING) || (mode_q == MODE_STOPPING);
      o_state_q  <= mode_code(mode_q);
      o_done_q   <= done_q;
      o_tper_q   <= tper_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pulse_width_o      = o_width_q;
  assign bridge_enable_o    = o_bridge_q;
  assign outputs_shutdown_o = o_shut_q;
  assign ramp_timer_run_o   = o_run_q;
  assign motor_state_o      = o_state_q;
  assign ramp_done_o        = o_done_q;
  assign timer_period_o     = o_tper_q;

endmodule

[src/mpsr_chk.sv]
module mpsr_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [7:0] cfg_pwm_freq_khz_i,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [2:0] req_type_i,
  input logic [1:0] direction_i,
  input logic [6:0] target_duty_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [9:0] pulse_width_o,
  input logic       bridge_enable_o,
  input logic       outputs_shutdown_o,
  input logic       ramp_timer_run_o,
  input logic [1:0] motor_state_o,
  input logic       ramp_done_o,
  input logic [7:0] timer_period_o
);
  import mpsr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pulse_width_o)
      && $stable(motor_state_o) && $stable(timer_period_o))
    else $error("output beat changed while stalled");

  a_bridge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bridge_enable_o == (motor_state_o != MS_INACTIVE))
    else $error("bridge enable disagrees with motor state");

  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ramp_timer_run_o ==
      (motor_state_o == MS_STARTING || motor_state_o == MS_STOPPING))
    else $error("ramp timer flag disagrees with motor state");

  a_shut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motor_state_o != MS_INACTIVE |-> !outputs_shutdown_o)
    else $error("outputs shut while bridge running");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ramp_done_o |-> motor_state_o == MS_ACTIVE
      || motor_state_o == MS_INACTIVE)
    else $error("ramp done reported mid ramp");

endmodule

bind motor_pwm_soft_ramp_top mpsr_chk u_mpsr_chk (.*);

[tb/sv/testbench.sv]
module testbench;
  import mpsr_pkg::*;

  localparam int unsigned CLOCK_KHZ    = 64000;
  localparam int unsigned MIN_FREQ_KHZ = 4;
  localparam int unsigned REST_DUTY    = 50;

  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned PRESSURE_PHASE = 4;
  localparam int unsigned NUM_PHASES     = 7;
  localparam int unsigned NUM_PLAN       = 25;

  // request codes the block does not decode
  localparam logic [2:0] REQ_SPARE5 = 3'd5;
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;

  typedef struct packed {
    logic [9:0] pulse_width;
    logic       bridge_enable;
    logic       outputs_shutdown;
    logic       ramp_timer_run;
    logic [1:0] motor_state;
    logic       ramp_done;
    logic [7:0] timer_period;
  } ramp_result_t;

  typedef struct packed {
    logic [2:0]   req;
    logic [1:0]   dir;
    logic [6:0]   tgt;
    logic         typed;
    ramp_result_t want;
  } plan_row_t;

  // at the reset frequency of 20 kHz: period 49, width 2 per duty percent
  localparam ramp_result_t IDLE_AT_20 =
    '{10'd0, 1'b0, 1'b1, 1'b0, MS_INACTIVE, 1'b0, 8'd49};
  localparam ramp_result_t ESTOP_AT_20 =
    '{10'd100, 1'b0, 1'b1, 1'b0, MS_INACTIVE, 1'b0, 8'd49};
  localparam ramp_result_t START_AT_20 =
    '{10'd100, 1'b1, 1'b0, 1'b1, MS_STARTING, 1'b0, 8'd49};

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_freq = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready_o;
  logic [2:0] req_type = 3'd0;
  logic [1:0] direction = 2'd0;
  logic [6:0] target_duty = 7'd0;
  logic       out_valid_o;
  logic       out_ready = 1'b0;
  logic [9:0] pulse_width_o;
  logic       bridge_enable_o;
  logic       outputs_shutdown_o;
  logic       ramp_timer_run_o;
  logic [1:0] motor_state_o;
  logic       ramp_done_o;
  logic [7:0] timer_period_o;

  int unsigned send_idle_pct = 20;
  int unsigned stall_pct = 20;
  int unsigned hold_left = 0;
  logic        hold_arm = 1'b0;
  int unsigned fail_cnt = 0;

  ramp_result_t expected_q[$];

  // shadow of the controller
  logic [7:0] freq_q = 8'd20;
  logic [1:0] motor_mode = MS_INACTIVE;
  logic [1:0] ramp_dir = DIR_NONE;
  logic [6:0] down_step = 7'd0;
  logic [6:0] up_step = 7'd0;
  logic [6:0] ramp_floor = 7'd0;
  logic [9:0] width_q = 10'd0;
  logic       shut_q = 1'b1;

  motor_pwm_soft_ramp_top #(
    .CLOCK_KHZ   (CLOCK_KHZ),
    .MIN_FREQ_KHZ(MIN_FREQ_KHZ),
    .REST_DUTY   (REST_DUTY)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_pwm_freq_khz_i(cfg_freq),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type),
    .direction_i       (direction),
    .target_duty_i     (target_duty),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .pulse_width_o     (pulse_width_o),
    .bridge_enable_o   (bridge_enable_o),
    .outputs_shutdown_o(outputs_shutdown_o),
    .ramp_timer_run_o  (ramp_timer_run_o),
    .motor_state_o     (motor_state_o),
    .ramp_done_o       (ramp_done_o),
    .timer_period_o    (timer_period_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned active_freq();
    return (freq_q < MIN_FREQ_KHZ) ? MIN_FREQ_KHZ : int'(freq_q);
  endfunction

  // invalid direction keeps the old width; extend mirrors the duty
  function automatic void duty_to_width(input logic [1:0] dir, input logic [6:0] duty);
    int unsigned d;
    int unsigned w;
    if (dir == DIR_INVALID) return;
    if (dir == DIR_EXTEND) d = (duty <= 100) ? 100 - duty : 0;
    else d = duty;
    w = (d * CLOCK_KHZ) / (active_freq() * 1600);
    width_q = w[9:0];
  endfunction

  function automatic void bridge_off();
    shut_q = 1'b1;
    motor_mode = MS_INACTIVE;
    ramp_dir = DIR_NONE;
  endfunction

  function automatic ramp_result_t next_motor_result(input logic [2:0] req,
                                                     input logic [1:0] dir,
                                                     input logic [6:0] tgt);
    ramp_result_t r;
    logic [6:0]   t;
    logic         done;
    int unsigned  w;
    int unsigned  q;
    done = 1'b0;
    t = tgt;
    case (req)
      REQ_START: begin
        if (motor_mode == MS_INACTIVE) begin
          if (t < 1) t = 7'd1;
          if (t > REST_DUTY) t = REST_DUTY[6:0];
          ramp_floor = t;
          ramp_dir = dir;
          motor_mode = MS_STARTING;
          down_step = REST_DUTY[6:0];
          duty_to_width(dir, down_step);
          shut_q = 1'b0;
        end
      end
      REQ_STOP: begin
        if (motor_mode == MS_ACTIVE) motor_mode = MS_STOPPING;
      end
      REQ_TICK: begin
        if (motor_mode == MS_STARTING) begin
          down_step = down_step - 7'd1;
          duty_to_width(ramp_dir, down_step);
          if (down_step < ramp_floor) begin
            up_step = ramp_floor;
            motor_mode = MS_ACTIVE;
            done = 1'b1;
          end
        end else if (motor_mode == MS_STOPPING) begin
          duty_to_width(ramp_dir, up_step);
          up_step = up_step + 7'd1;
          if (up_step > REST_DUTY) begin
            bridge_off();
            done = 1'b1;
          end
        end
      end
      REQ_ESTOP: begin
        w = REST_DUTY * (CLOCK_KHZ / (active_freq() * 1600));
        width_q = w[9:0];
        bridge_off();
      end
      REQ_OFF: begin
        if (motor_mode != MS_INACTIVE) bridge_off();
      end
      default: ;
    endcase
    q = CLOCK_KHZ / (active_freq() * 64) - 1;
    r.pulse_width = width_q;
    r.bridge_enable = (motor_mode != MS_INACTIVE);
    r.outputs_shutdown = shut_q;
    r.ramp_timer_run = (motor_mode == MS_STARTING) || (motor_mode == MS_STOPPING);
    r.motor_state = motor_mode;
    r.ramp_done = done;
    r.timer_period = q[7:0];
    return r;
  endfunction

  task automatic offer(input logic [2:0] req, input logic [1:0] dir, input logic [6:0] tgt,
                       input logic typed, input ramp_result_t want);
    ramp_result_t pred;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    req_type <= req;
    direction <= dir;
    target_duty <= tgt;
    do @(posedge clk_i); while (!in_ready_o);
    pred = next_motor_result(req, dir, tgt);
    expected_q.push_back(typed ? want : pred);
  endtask

  task automatic set_freq(input logic [7:0] f);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_freq <= f;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    freq_q = f;
  endtask

  // mostly complete start/stop ramps driven from the shadow state, some noise
  task automatic pick_item(output logic [2:0] req, output logic [1:0] dir,
                           output logic [6:0] tgt);
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(99);
    dir = 2'($urandom_range(3));
    tgt = 7'($urandom_range(127));
    if (roll < 12) begin
      req = 3'($urandom_range(7));
    end else if (roll < 15) begin
      req = $urandom_range(1) ? REQ_ESTOP : REQ_OFF;
    end else begin
      case (motor_mode)
        MS_INACTIVE: begin
          req = REQ_START;
          pick = $urandom_range(99);
          if (pick < 60) tgt = 7'($urandom_range(50, 38));
          else if (pick < 85) tgt = 7'($urandom_range(37, 0));
          else tgt = 7'($urandom_range(127, 51));
        end
        MS_ACTIVE: req = REQ_STOP;
        default:   req = REQ_TICK;
      endcase
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_arm) begin
      hold_arm = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    ramp_result_t got;
    ramp_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      got = {pulse_width_o, bridge_enable_o, outputs_shutdown_o, ramp_timer_run_o,
             motor_state_o, ramp_done_o, timer_period_o};
      if (expected_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) $display("unexpected result beat %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got.pulse_width !== want.pulse_width ||
            got.bridge_enable !== want.bridge_enable ||
            got.outputs_shutdown !== want.outputs_shutdown ||
            got.ramp_timer_run !== want.ramp_timer_run ||
            got.motor_state !== want.motor_state ||
            got.ramp_done !== want.ramp_done ||
            got.timer_period !== want.timer_period) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("mismatch exp pw=%0d en=%0d sd=%0d run=%0d st=%0d done=%0d per=%0d",
                     want.pulse_width, want.bridge_enable, want.outputs_shutdown,
                     want.ramp_timer_run, want.motor_state, want.ramp_done,
                     want.timer_period);
            $display("         got pw=%0d en=%0d sd=%0d run=%0d st=%0d done=%0d per=%0d",
                     got.pulse_width, got.bridge_enable, got.outputs_shutdown,
                     got.ramp_timer_run, got.motor_state, got.ramp_done,
                     got.timer_period);
          end
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t    plan [NUM_PLAN];
    ramp_result_t none;
    logic [2:0]   r;
    logic [1:0]   d;
    logic [6:0]   t;
    logic [7:0]   f;
    int unsigned  count;
    int unsigned  n;

    none = '0;
    // no-op commands, start/estop corners at 20 kHz, then shadow-predicted rows
    plan[0]  = '{REQ_TICK,   DIR_NONE,     7'd0,   1'b1, IDLE_AT_20};
    plan[1]  = '{REQ_STOP,   DIR_NONE,     7'd0,   1'b1, IDLE_AT_20};
    plan[2]  = '{REQ_OFF,    DIR_NONE,     7'd0,   1'b1, IDLE_AT_20};
    plan[3]  = '{REQ_SPARE5, DIR_INVALID,  7'd127, 1'b1, IDLE_AT_20};
    plan[4]  = '{REQ_SPARE7, DIR_NONE,     7'd0,   1'b1, IDLE_AT_20};
    plan[5]  = '{REQ_ESTOP,  DIR_NONE,     7'd0,   1'b1, ESTOP_AT_20};
    plan[6]  = '{REQ_START,  DIR_NONE,     7'd0,   1'b1, START_AT_20};
    plan[7]  = '{REQ_START,  DIR_EXTEND,   7'd100, 1'b1, START_AT_20};
    plan[8]  = '{REQ_ESTOP,  DIR_NONE,     7'd0,   1'b1, ESTOP_AT_20};
    plan[9]  = '{REQ_START,  DIR_EXTEND,   7'd127, 1'b1, START_AT_20};
    plan[10] = '{REQ_TICK,   DIR_NONE,     7'd0,   1'b0, none};
    plan[11] = '{REQ_TICK,   DIR_NONE,     7'd0,   1'b0, none};
    plan[12] = '{REQ_START,  DIR_NONE,     7'd0,   1'b0, none};
    plan[13] = '{REQ_STOP,   DIR_NONE,     7'd0,   1'b0, none};
    plan[14] = '{REQ_STOP,   DIR_NONE,     7'd0,   1'b0, none};
    plan[15] = '{REQ_TICK,   DIR_NONE,     7'd0,   1'b0, none};
    plan[16] = '{REQ_START,  DIR_CONTRACT, 7'd49,  1'b0, none};
    plan[17] = '{REQ_TICK,   DIR_NONE,     7'd0,   1'b0, none};
    plan[18] = '{REQ_TICK,   DIR_NONE,     7'd0,   1'b0, none};
    plan[19] = '{REQ_OFF,    DIR_NONE,     7'd0,   1'b0, none};
    plan[20] = '{REQ_START,  DIR_INVALID,  7'd50,  1'b0, none};
    plan[21] = '{REQ_TICK,   DIR_NONE,     7'd0,   1'b0, none};
    plan[22] = '{REQ_STOP,   DIR_NONE,     7'd0,   1'b0, none};
    plan[23] = '{REQ_TICK,   DIR_NONE,     7'd0,   1'b0, none};
    plan[24] = '{REQ_SPARE6, DIR_NONE,     7'd0,   1'b0, none};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_PLAN; i++) begin
      offer(plan[i].req, plan[i].dir, plan[i].tgt, plan[i].typed, plan[i].want);
    end
    in_valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      count = 120;
      case (p)
        0: begin f = 8'd255; send_idle_pct = 0;  stall_pct = 0;  count = 140; end
        1: begin f = 8'd0;   send_idle_pct = 70; stall_pct = 0;  end
        2: begin f = 8'd1;   send_idle_pct = 0;  stall_pct = 70; end
        3: begin f = 8'd4;   send_idle_pct = 20; stall_pct = 20; end
        4: begin
          f = 8'($urandom_range(254, 5)); send_idle_pct = 0; stall_pct = 0; count = 110;
        end
        5: begin f = 8'($urandom_range(255)); send_idle_pct = 20; stall_pct = 20; end
        default: begin f = 8'd20; send_idle_pct = 0; stall_pct = 0; end
      endcase
      set_freq(f);
      if (p == PRESSURE_PHASE) begin
        // output held off while beats keep coming in
        @(negedge clk_i);
        hold_arm = 1'b1;
        @(posedge clk_i);
      end
      n = 0;
      while (n < count) begin
        pick_item(r, d, t);
        offer(r, d, t, 1'b0, none);
        n++;
      end
      in_valid <= 1'b0;
    end

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
